// File: hw/rtl/inc_pkg.sv
// Shared types and constants for the inverse normal CDF pipeline.
// No dependencies; imported by every inc_* module and the top level.
`default_nettype none

package inc_pkg;

	// fraction bits of the quantile output
	localparam int FRAC_BITS = 28;

	localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

	// rational approximation coefficients, Q.32 rounded from six decimals
	localparam logic [33:0] COEF_C0 = 34'(((64'd2515517 << 32) + 64'd500000) / 64'd1000000);
	localparam logic [33:0] COEF_C1 = 34'(((64'd802853 << 32) + 64'd500000) / 64'd1000000);
	localparam logic [33:0] COEF_C2 = 34'(((64'd10328 << 32) + 64'd500000) / 64'd1000000);
	localparam logic [33:0] COEF_D1 = 34'(((64'd1432788 << 32) + 64'd500000) / 64'd1000000);
	localparam logic [33:0] COEF_D2 = 34'(((64'd189269 << 32) + 64'd500000) / 64'd1000000);
	localparam logic [33:0] COEF_D3 = 34'(((64'd1308 << 32) + 64'd500000) / 64'd1000000);

	// output rescale: right shift with rounding, or left shift capped at 16
	localparam int SHR = (FRAC_BITS < 32) ? (32 - FRAC_BITS) : 0;
	localparam int SHL = (FRAC_BITS > 48) ? 16 : ((FRAC_BITS > 32) ? (FRAC_BITS - 32) : 0);
	localparam logic [56:0] RND_ADD = (57'd1 << SHR) >> 1;

	typedef struct packed {
		logic lower;    // p below one half: result negated
		logic invalid;  // p == 0
	} inc_tag_t;

endpackage

`default_nettype wire

// File: hw/rtl/inc_log2.sv
// Tail select, -log2 by 32 pipelined squaring steps, then s = -2 ln q.
// Depends on inc_pkg.
`default_nettype none

module inc_log2 import inc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] x,
	output logic        out_valid,
	output inc_tag_t    out_tag,
	output logic [37:0] s
);

	localparam int N = 32;

	logic        v_s   [0:N];
	inc_tag_t    tag_s [0:N];
	logic [4:0]  e_s   [0:N];
	logic [31:0] m_s   [0:N];
	logic [31:0] f_s   [0:N];

	logic        lower;
	logic [31:0] q;
	logic [4:0]  e;

	always_comb begin
		lower = ~x[31];
		q = lower ? x : (32'd0 - x);
		e = '0;
		for (int i = 0; i < 32; i++) begin
			if (q[i]) e = 5'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= '{lower: lower, invalid: (x == 32'd0)};
			e_s[0]   <= e;
			m_s[0]   <= q << (5'd31 - e);
			f_s[0]   <= '0;
		end
	end

	// one squaring per stage; mantissa stays in [1,2) as Q1.31
	for (genvar i = 1; i <= N; i++) begin : g_sq
		logic [63:0] prod;
		logic [32:0] sq;
		assign prod = 64'(m_s[i-1]) * 64'(m_s[i-1]);
		assign sq   = prod[63:31];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i] <= 1'b0;
			else if (en) v_s[i] <= v_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[i] <= tag_s[i-1];
				e_s[i]   <= e_s[i-1];
				if (sq[32]) begin
					m_s[i] <= sq[32:1];
					f_s[i] <= f_s[i-1] | (32'd1 << (N - i));
				end else begin
					m_s[i] <= sq[31:0];
					f_s[i] <= f_s[i-1];
				end
			end
		end
	end

	// L = (32 - e) - f, Q.32
	logic        v_l_s;
	inc_tag_t    tag_l_s;
	logic [5:0]  lint_l_s;
	logic [31:0] lfrac_l_s;
	logic [37:0] l_val;

	assign l_val = {6'd32 - {1'b0, e_s[N]}, 32'd0} - {6'd0, f_s[N]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_l_s <= 1'b0;
		else if (en) v_l_s <= v_s[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_l_s   <= tag_s[N];
			lint_l_s  <= l_val[37:32];
			lfrac_l_s <= l_val[31:0];
		end
	end

	// s = 2 * (L * ln2), fraction product truncated
	logic [63:0] pf;
	logic [37:0] acc;
	logic        v_x_s;
	inc_tag_t    tag_x_s;
	logic [37:0] s_x_s;

	assign pf  = 64'(lfrac_l_s) * 64'(LN2_Q32);
	assign acc = 38'(lint_l_s) * 38'(LN2_Q32) + 38'(pf[63:32]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_x_s <= 1'b0;
		else if (en) v_x_s <= v_l_s;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_x_s <= tag_l_s;
			s_x_s   <= {acc[36:0], 1'b0};
		end
	end

	assign out_valid = v_x_s;
	assign out_tag   = tag_x_s;
	assign s         = s_x_s;

`ifndef SYNTHESIS
	a_mant_norm: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] && !tag_s[0].invalid |-> m_s[0][31])
		else $error("log2 mantissa not normalized");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/inc_sqrt.sv
// Integer square root of s * 2^26, one result bit per pipeline stage.
// Depends on inc_pkg.
`default_nettype none

module inc_sqrt import inc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  inc_tag_t    in_tag,
	input  logic [37:0] s,
	output logic        out_valid,
	output inc_tag_t    out_tag,
	output logic [31:0] r
);

	localparam int N = 32;

	logic        v_s   [0:N];
	inc_tag_t    tag_s [0:N];
	logic [63:0] rem_s [0:N];
	logic [63:0] res_s [0:N];

	always_comb begin
		v_s[0]   = in_valid;
		tag_s[0] = in_tag;
		rem_s[0] = {s, 26'd0};
		res_s[0] = '0;
	end

	for (genvar j = 1; j <= N; j++) begin : g_bit
		localparam logic [63:0] BIT = 64'd1 << (2 * (N - j));
		logic [63:0] trial;
		assign trial = res_s[j-1] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j] <= 1'b0;
			else if (en) v_s[j] <= v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[j] <= tag_s[j-1];
				if (rem_s[j-1] >= trial) begin
					rem_s[j] <= rem_s[j-1] - trial;
					res_s[j] <= (res_s[j-1] >> 1) + BIT;
				end else begin
					rem_s[j] <= rem_s[j-1];
					res_s[j] <= res_s[j-1] >> 1;
				end
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_tag   = tag_s[N];
	assign r         = res_s[N][31:0];

`ifndef SYNTHESIS
	a_root_fits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[N] |-> res_s[N][63:32] == 32'd0)
		else $error("square root exceeds 32 bits");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/inc_ratio.sv
// Horner evaluation of numerator and denominator, then a 40-stage restoring
// divider for the Q.32 ratio. Depends on inc_pkg.
`default_nettype none

module inc_ratio import inc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  inc_tag_t    in_tag,
	input  logic [31:0] r,
	output logic        out_valid,
	output inc_tag_t    out_tag,
	output logic [31:0] r_out,
	output logic [39:0] ratio
);

	// t32 = r << 3, so (c * t32) >> 32 == (c * r) >> 29
	logic        v_h1_s, v_h2_s, v_h3_s, v_h4_s;
	inc_tag_t    tag_h1_s, tag_h2_s, tag_h3_s, tag_h4_s;
	logic [31:0] r_h1_s, r_h2_s, r_h3_s, r_h4_s;
	logic [63:0] pa_h1_s, pb_h1_s;
	logic [65:0] pa_h2_s, pb_h2_s, pb_h3_s;
	logic [39:0] num_h3_s, num_h4_s;
	logic [37:0] den_h4_s;

	logic [33:0] a2, b2, b3;
	assign a2 = 34'(pa_h1_s >> 29) + COEF_C1;
	assign b2 = 34'(pb_h1_s >> 29) + COEF_D2;
	assign b3 = 34'(pb_h2_s >> 29) + COEF_D1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_h1_s <= 1'b0;
			v_h2_s <= 1'b0;
			v_h3_s <= 1'b0;
			v_h4_s <= 1'b0;
		end else if (en) begin
			v_h1_s <= in_valid;
			v_h2_s <= v_h1_s;
			v_h3_s <= v_h2_s;
			v_h4_s <= v_h3_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_h1_s <= in_tag;
			r_h1_s   <= r;
			pa_h1_s  <= 64'(COEF_C2[31:0]) * 64'(r);
			pb_h1_s  <= 64'(COEF_D3[31:0]) * 64'(r);

			tag_h2_s <= tag_h1_s;
			r_h2_s   <= r_h1_s;
			pa_h2_s  <= 66'(a2) * 66'(r_h1_s);
			pb_h2_s  <= 66'(b2) * 66'(r_h1_s);

			tag_h3_s <= tag_h2_s;
			r_h3_s   <= r_h2_s;
			num_h3_s <= 40'(pa_h2_s >> 29) + 40'(COEF_C0);
			pb_h3_s  <= 66'(b3) * 66'(r_h2_s);

			tag_h4_s <= tag_h3_s;
			r_h4_s   <= r_h3_s;
			num_h4_s <= num_h3_s;
			den_h4_s <= 38'(pb_h3_s >> 29) + (38'd1 << 32);
		end
	end

	// restoring division of num * 2^32 by den; quotient fits 40 bits
	localparam int N = 40;

	logic        v_s    [0:N];
	inc_tag_t    tag_s  [0:N];
	logic [31:0] rr_s   [0:N];
	logic [37:0] rem_s  [0:N];
	logic [37:0] den_s  [0:N];
	logic [7:0]  nlo_s  [0:N];
	logic [39:0] quo_s  [0:N];

	always_comb begin
		v_s[0]   = v_h4_s;
		tag_s[0] = tag_h4_s;
		rr_s[0]  = r_h4_s;
		rem_s[0] = 38'(num_h4_s[39:8]);
		den_s[0] = den_h4_s;
		nlo_s[0] = num_h4_s[7:0];
		quo_s[0] = '0;
	end

	for (genvar j = 1; j <= N; j++) begin : g_div
		logic        dbit;
		logic [38:0] sh;
		logic        ge;

		if (j <= 8) begin : g_num
			assign dbit = nlo_s[j-1][8 - j];
		end else begin : g_zero
			assign dbit = 1'b0;
		end

		assign sh = {rem_s[j-1], dbit};
		assign ge = sh >= {1'b0, den_s[j-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j] <= 1'b0;
			else if (en) v_s[j] <= v_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[j] <= tag_s[j-1];
				rr_s[j]  <= rr_s[j-1];
				den_s[j] <= den_s[j-1];
				nlo_s[j] <= nlo_s[j-1];
				quo_s[j] <= {quo_s[j-1][38:0], ge};
				rem_s[j] <= ge ? 38'(sh - {1'b0, den_s[j-1]}) : sh[37:0];
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_tag   = tag_s[N];
	assign r_out     = rr_s[N];
	assign ratio     = quo_s[N];

`ifndef SYNTHESIS
	a_den_min: assert property (@(posedge clk) disable iff (!arst_n)
		v_h4_s |-> den_h4_s[37:32] != 6'd0)
		else $error("denominator below one");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[N] |-> rem_s[N] < den_s[N])
		else $error("division remainder out of range");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/inverse_normal_cdf.sv
// Top level: inverse normal CDF (rational approximation), fully pipelined.
// Depends on inc_pkg, inc_log2, inc_sqrt, inc_ratio.
//
//   channel  valid         ready         word
//   input    prob_valid    prob_ready    prob_fraction[31:0]
//   output   result_valid  result_ready  quantile[31:0], invalid
//
// One word enters per clock unless a held output freezes the pipeline; the stages are
// log2/ln, square root, Horner and divide, sign/magnitude, then the output register.
// The 40-bit divider and the 32 squaring stages set the depth.
// A held output freezes the pipeline only once the stage behind it is full.
// arst_n clears all valid bits; payload registers are not reset.
`default_nettype none

module inverse_normal_cdf import inc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        prob_valid,
	output logic        prob_ready,
	input  logic [31:0] prob_fraction,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] quantile,
	output logic        invalid
);

	logic        en;
	logic        out_free;

	logic        lg_valid;
	inc_tag_t    lg_tag;
	logic [37:0] lg_s;

	logic        sq_valid;
	inc_tag_t    sq_tag;
	logic [31:0] sq_r;

	logic        rt_valid;
	inc_tag_t    rt_tag;
	logic [31:0] rt_r;
	logic [39:0] rt_ratio;

	logic        v_f1_s;
	inc_tag_t    tag_f1_s;
	logic        neg_f1_s;
	logic [39:0] mag_f1_s;

	logic        result_valid_q;
	logic [31:0] quantile_q;
	logic        invalid_q;

	assign out_free   = !result_valid_q || result_ready;
	assign en         = out_free || !v_f1_s;
	assign prob_ready = en;

	inc_log2 u_log2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (prob_valid),
		.x        (prob_fraction),
		.out_valid(lg_valid),
		.out_tag  (lg_tag),
		.s        (lg_s)
	);

	inc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (lg_valid),
		.in_tag   (lg_tag),
		.s        (lg_s),
		.out_valid(sq_valid),
		.out_tag  (sq_tag),
		.r        (sq_r)
	);

	inc_ratio u_ratio (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.in_tag   (sq_tag),
		.r        (sq_r),
		.out_valid(rt_valid),
		.out_tag  (rt_tag),
		.r_out    (rt_r),
		.ratio    (rt_ratio)
	);

	// z = t - ratio as sign and magnitude
	logic [39:0] t40;
	logic        t_ge;
	assign t40  = {5'd0, rt_r, 3'd0};
	assign t_ge = t40 >= rt_ratio;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_f1_s <= 1'b0;
		else if (en) v_f1_s <= rt_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_f1_s <= rt_tag;
			neg_f1_s <= (!t_ge) ^ rt_tag.lower;
			mag_f1_s <= t_ge ? (t40 - rt_ratio) : (rt_ratio - t40);
		end
	end

	// rescale, round half away from zero on the magnitude, saturate; invalid words give zero
	logic [56:0] scaled;
	logic [31:0] q_word;
	always_comb begin
		scaled = ((57'(mag_f1_s) + RND_ADD) >> SHR) << SHL;
		if (tag_f1_s.invalid) begin
			q_word = '0;
		end else if (neg_f1_s) begin
			q_word = (scaled > 57'h80000000) ? 32'h80000000 : (32'd0 - scaled[31:0]);
		end else begin
			q_word = (scaled > 57'h7FFFFFFF) ? 32'h7FFFFFFF : scaled[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid_q <= 1'b0;
		else if (out_free) result_valid_q <= v_f1_s;
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			quantile_q <= q_word;
			invalid_q  <= tag_f1_s.invalid;
		end
	end

	assign result_valid = result_valid_q;
	assign quantile     = quantile_q;
	assign invalid      = invalid_q;

`ifndef SYNTHESIS
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && invalid_q |-> quantile_q == 32'd0)
		else $error("invalid word with nonzero quantile");
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_q |-> prob_ready)
		else $error("input stalled with empty output");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_inverse_normal_cdf.sv
// Testbench for inverse_normal_cdf: drives probability words, predicts each quantile
// with a bit-exact fixed-point model and compares results in order. Depends on inc_pkg.
`default_nettype none

module tb_inverse_normal_cdf;
	import inc_pkg::*;

	localparam int LATENCY = 113;
	localparam int STALL_LIMIT = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        prob_valid = 1'b0;
	logic        prob_ready;
	logic [31:0] prob_fraction = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [31:0] quantile;
	logic        invalid;

	typedef struct {
		logic [31:0] quantile;
		logic        invalid;
	} quantile_word_t;

	quantile_word_t pending_quantiles[$];
	int  error_count = 0;
	int  idle_cycles = 0;
	bit  stim_done = 1'b0;

	inverse_normal_cdf uut (
		.clk(clk), .arst_n(arst_n),
		.prob_valid(prob_valid), .prob_ready(prob_ready), .prob_fraction(prob_fraction),
		.result_valid(result_valid), .result_ready(result_ready),
		.quantile(quantile), .invalid(invalid)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] mul_frac32(logic [63:0] a, logic [63:0] b);
		logic [127:0] prod;
		prod = 128'(a) * 128'(b);
		return prod[95:32];
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else
				res >>= 1;
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic quantile_word_t predict_quantile(logic [31:0] x);
		quantile_word_t r;
		logic [63:0] q, m, f, lg, s, t32, num, den, ratio, mag;
		logic [127:0] wide;
		int e;
		bit lower, neg;
		r.invalid = 1'b0;
		if (x == 0) begin
			r.quantile = '0;
			r.invalid = 1'b1;
			return r;
		end
		lower = x < 32'h8000_0000;
		q = lower ? 64'(x) : (64'd1 << 32) - 64'(x);
		e = 0;
		while (e < 31 && (q >> (e + 1)) != 0) e++;
		m = q << (31 - e);
		f = 0;
		for (int i = 1; i <= 32; i++) begin
			m = (m * m) >> 31;
			if (m >= (64'd1 << 32)) begin
				f |= 64'd1 << (32 - i);
				m >>= 1;
			end
		end
		lg = (64'(32 - e) << 32) - f;
		s = 2 * ((lg >> 32) * 64'(LN2_Q32) + (((lg & 64'hFFFF_FFFF) * 64'(LN2_Q32)) >> 32));
		t32 = int_sqrt(s << 26) << 3;
		num = mul_frac32(mul_frac32(64'(COEF_C2), t32) + 64'(COEF_C1), t32) + 64'(COEF_C0);
		den = mul_frac32(mul_frac32(mul_frac32(64'(COEF_D3), t32) + 64'(COEF_D2), t32)
			+ 64'(COEF_D1), t32) + (64'd1 << 32);
		wide = (128'(num) << 32) / 128'(den);
		ratio = wide[63:0];
		if (t32 >= ratio) begin
			mag = t32 - ratio;
			neg = 1'b0;
		end else begin
			mag = ratio - t32;
			neg = 1'b1;
		end
		if (lower) neg = !neg;
		if (FRAC_BITS < 32)
			mag = (mag + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
		else if (FRAC_BITS > 32)
			mag <<= ((FRAC_BITS - 32) > 16 ? 16 : (FRAC_BITS - 32));
		if (neg) begin
			if (mag > 64'h8000_0000) mag = 64'h8000_0000;
			r.quantile = 32'(-mag);
		end else begin
			if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
			r.quantile = mag[31:0];
		end
		return r;
	endfunction

	// valid is dropped only when a gap is drawn; the caller drops it after the last word
	task automatic send_prob(logic [31:0] x);
		int gap;
		gap = $urandom_range(0, 7);
		if (gap != 0) begin
			prob_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		prob_valid <= 1'b1;
		prob_fraction <= x;
		pending_quantiles.push_back(predict_quantile(x));
		do @(posedge clk); while (!prob_ready);
	endtask

	// back-to-back words: valid stays high across accepts
	task automatic send_burst(int n);
		logic [31:0] x;
		for (int i = 0; i < n; i++) begin
			x = $urandom;
			prob_valid <= 1'b1;
			prob_fraction <= x;
			pending_quantiles.push_back(predict_quantile(x));
			do @(posedge clk); while (!prob_ready);
		end
	endtask

	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			if (pending_quantiles.size() == 0) begin
				$error("unexpected word: quantile %h invalid %b", quantile, invalid);
				error_count++;
			end else begin
				quantile_word_t exp_word;
				exp_word = pending_quantiles.pop_front();
				if (quantile !== exp_word.quantile) begin
					$error("quantile: expected %h actual %h", exp_word.quantile, quantile);
					error_count++;
				end
				if (invalid !== exp_word.invalid) begin
					$error("invalid: expected %b actual %b", exp_word.invalid, invalid);
					error_count++;
				end
			end
		end
	end

	// receiver: random stalls, with occasional long always-ready stretches
	initial begin
		int gap;
		int streak;
		streak = 0;
		forever begin
			@(posedge clk);
			if (streak > 0) begin
				streak--;
				result_ready <= 1'b1;
			end else if ($urandom_range(0, 15) == 0) begin
				streak = $urandom_range(20, 200);
				result_ready <= 1'b1;
			end else begin
				gap = $urandom_range(0, 7);
				if (gap != 0) begin
					result_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				result_ready <= 1'b1;
				do @(posedge clk); while (!result_valid);
			end
		end
	end

	always @(posedge clk) begin
		if ((prob_valid && prob_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else if (!stim_done || pending_quantiles.size() != 0)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("inverse_normal_cdf regression: fail");
			$finish;
		end
	end

	task automatic test_edges();
		logic [31:0] edge_vals[] = '{32'h0, 32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h4000_0000, 32'hC000_0000,
			32'h0000_0100, 32'hFFFF_FF00, 32'h0001_0000, 32'h1000_0000, 32'hF000_0000,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'h7FFF_0000};
		foreach (edge_vals[i]) send_prob(edge_vals[i]);
	endtask

	task automatic test_random_uniform(int n);
		for (int i = 0; i < n; i++) send_prob($urandom);
	endtask

	// tails: small q so the log and saturation-free extremes get exercised
	task automatic test_random_tails(int n);
		logic [31:0] x;
		for (int i = 0; i < n; i++) begin
			x = $urandom >> $urandom_range(0, 31);
			if ($urandom_range(0, 1)) x = ~x;
			send_prob(x);
		end
	endtask

	task automatic test_full_rate();
		for (int i = 0; i < 4; i++) send_burst($urandom_range(30, 60));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edges();
		test_random_uniform(400);
		test_random_tails(250);
		test_full_rate();
		prob_valid <= 1'b0;
		stim_done = 1'b1;
		while (pending_quantiles.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (error_count == 0)
			$display("inverse_normal_cdf regression: pass");
		else
			$display("inverse_normal_cdf regression: fail");
		$finish;
	end
endmodule

`default_nettype wire
